// ===== rtl/scanline_edgel_detector_macros.svh =====
// Assertion macros used by the checker file of the edgel detector.
`ifndef SCANLINE_EDGEL_DETECTOR_MACROS_SVH
`define SCANLINE_EDGEL_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SED_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SED_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sed_pkg.sv =====
`default_nettype none

package sed_pkg;

	localparam int unsigned IDX_W      = 12;
	localparam int unsigned RESP_W     = 11;
	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned NUM_CHAN   = 3;
	localparam int unsigned PIX_W      = CHAN_W * NUM_CHAN;
	localparam int unsigned WIN_DEPTH  = 4;
	localparam int unsigned FILL_W     = $clog2(WIN_DEPTH + 1);
	localparam int unsigned EDGEL_LAG  = 3;

	localparam int unsigned S_DATA_BITS = PIX_W + 2 * IDX_W;
	localparam int unsigned S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
	localparam int unsigned M_DATA_BITS = 2 * IDX_W + RESP_W;
	localparam int unsigned M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;

	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_IDX_W = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [RESP_W-1:0] THRESH_RESET = RESP_W'(16 * 16);

	// Classified pixel handed from the front to the back.
	typedef struct packed {
		logic              line_start;
		logic [RESP_W-1:0] resp;
		logic [IDX_W-1:0]  pixel;
		logic [IDX_W-1:0]  line;
	} entry_t;

	// One result transaction.
	typedef struct packed {
		logic              found;
		logic [IDX_W-1:0]  pixel;
		logic [IDX_W-1:0]  line;
		logic [RESP_W-1:0] strength;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/sed_front.sv =====
`default_nettype none

module sed_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [sed_pkg::RESP_W-1:0]   cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [sed_pkg::PIX_W-1:0]    pix,
	input  wire logic                         line_start,
	input  wire logic [sed_pkg::IDX_W-1:0]    pixel_index,
	input  wire logic [sed_pkg::IDX_W-1:0]    line_number,
	output logic                              push_valid,
	input  wire logic                         push_ready,
	output sed_pkg::entry_t                   push_data
);

	logic [sed_pkg::RESP_W-1:0] thresh_q;
	logic [sed_pkg::PIX_W-1:0]  win_q [sed_pkg::WIN_DEPTH];
	logic [sed_pkg::FILL_W-1:0] fill_q;

	logic [sed_pkg::FILL_W-1:0] fill_eff;
	logic [sed_pkg::RESP_W-1:0] mag [sed_pkg::NUM_CHAN];
	logic                       all_edge;
	logic [sed_pkg::RESP_W-1:0] current;
	logic                       accept;

	// |5*d + 3*e - 5*b - 3*a|, at most 2040
	function automatic logic [sed_pkg::RESP_W-1:0] kernel_mag(
		input logic [sed_pkg::CHAN_W-1:0] a,
		input logic [sed_pkg::CHAN_W-1:0] b,
		input logic [sed_pkg::CHAN_W-1:0] d,
		input logic [sed_pkg::CHAN_W-1:0] e
	);
		logic [sed_pkg::RESP_W:0] pos;
		logic [sed_pkg::RESP_W:0] neg;
		logic [sed_pkg::RESP_W:0] diff;
		pos  = (sed_pkg::RESP_W+1)'(d) * (sed_pkg::RESP_W+1)'(5)
		     + (sed_pkg::RESP_W+1)'(e) * (sed_pkg::RESP_W+1)'(3);
		neg  = (sed_pkg::RESP_W+1)'(b) * (sed_pkg::RESP_W+1)'(5)
		     + (sed_pkg::RESP_W+1)'(a) * (sed_pkg::RESP_W+1)'(3);
		diff = (pos >= neg) ? (pos - neg) : (neg - pos);
		return diff[sed_pkg::RESP_W-1:0];
	endfunction

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid && push_ready;

	always_comb begin
		// a line start empties the window before this pixel is looked at
		fill_eff = line_start ? '0 : fill_q;
		all_edge = 1'b1;
		for (int c = 0; c < sed_pkg::NUM_CHAN; c++) begin
			mag[c] = kernel_mag(win_q[0][c*sed_pkg::CHAN_W +: sed_pkg::CHAN_W],
			                    win_q[1][c*sed_pkg::CHAN_W +: sed_pkg::CHAN_W],
			                    win_q[3][c*sed_pkg::CHAN_W +: sed_pkg::CHAN_W],
			                    pix[c*sed_pkg::CHAN_W +: sed_pkg::CHAN_W]);
			if (!(mag[c] > thresh_q)) begin
				all_edge = 1'b0;
			end
		end
		current = (fill_eff == sed_pkg::FILL_W'(sed_pkg::WIN_DEPTH) && all_edge)
		          ? mag[0] : '0;
	end

	always_comb begin
		push_data.line_start = line_start;
		push_data.resp       = current;
		push_data.pixel      = pixel_index - sed_pkg::IDX_W'(sed_pkg::EDGEL_LAG);
		push_data.line       = line_number;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= sed_pkg::THRESH_RESET;
			fill_q   <= '0;
		end else begin
			if (cfg_we) begin
				thresh_q <= cfg_wdata;
			end
			if (accept) begin
				fill_q <= (fill_eff < sed_pkg::FILL_W'(sed_pkg::WIN_DEPTH))
				          ? fill_eff + sed_pkg::FILL_W'(1) : fill_eff;
			end
		end
	end

	// window contents only count once the fill count says so
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < sed_pkg::WIN_DEPTH - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[sed_pkg::WIN_DEPTH-1] <= pix;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sed_queue.sv =====
`default_nettype none

module sed_queue (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push_valid,
	output logic           push_ready,
	input  wire sed_pkg::entry_t push_data,
	output logic           pop_valid,
	input  wire logic      pop_ready,
	output sed_pkg::entry_t pop_data
);

	sed_pkg::entry_t             mem_q [sed_pkg::Q_DEPTH];
	logic [sed_pkg::Q_IDX_W-1:0] wr_ptr_q;
	logic [sed_pkg::Q_IDX_W-1:0] rd_ptr_q;
	logic [sed_pkg::Q_CNT_W-1:0] cnt_q;
	logic                        push;
	logic                        pop;

	assign push_ready = (cnt_q != sed_pkg::Q_CNT_W'(sed_pkg::Q_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + sed_pkg::Q_IDX_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + sed_pkg::Q_IDX_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + sed_pkg::Q_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - sed_pkg::Q_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sed_back.sv =====
`default_nettype none

module sed_back (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       pop_valid,
	output logic            pop_ready,
	input  wire sed_pkg::entry_t pop_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output sed_pkg::result_t out_data
);

	logic                       out_valid_q;
	sed_pkg::result_t           out_q;
	logic [sed_pkg::RESP_W-1:0] prev1_q;
	logic [sed_pkg::RESP_W-1:0] prev2_q;

	logic [sed_pkg::RESP_W-1:0] p1;
	logic [sed_pkg::RESP_W-1:0] p2;
	logic                       found;
	logic                       take;

	assign pop_ready = !out_valid_q || out_ready;
	assign take      = pop_valid && pop_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		// drop the response history at a line start
		p1    = pop_data.line_start ? '0 : prev1_q;
		p2    = pop_data.line_start ? '0 : prev2_q;
		found = (p1 != '0) && (p1 > p2) && (p1 > pop_data.resp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			prev1_q     <= '0;
			prev2_q     <= '0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
				prev2_q     <= p1;
				prev1_q     <= pop_data.resp;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q.found    <= found;
			out_q.pixel    <= found ? pop_data.pixel : '0;
			out_q.line     <= found ? pop_data.line : '0;
			out_q.strength <= found ? p1 : '0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/scanline_edgel_detector.sv =====
// Channel   Dir  Fields (tdata low bit up)                        tuser
// s_axis    in   red, green, blue, pixel_index, line_number        line_start
// m_axis    out  edgel_pixel, edgel_line, edgel_strength, zero pad edgel_found
// cfg       in   edge_threshold (write only, reset 256)            -
//
// One pixel in and one result out per clock when both sides flow; a pixel
// passes through the queue and the output register before it leaves as a result.
// The front holds the window and threshold; the back holds the response
// history and the output register. A four-entry queue between them keeps
// the input flowing while the output stalls, and s_axis_tready drops only
// once that queue is full.
// arst_n clears the fill count, response history, queue and output valid,
// and loads the threshold reset value.
`default_nettype none

module scanline_edgel_detector (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration: threshold written whenever cfg_we is high
	input  wire logic                           cfg_we,
	input  wire logic [sed_pkg::RESP_W-1:0]     cfg_wdata,
	// pixel stream
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// red, green, blue, pixel_index, line_number
	input  wire logic [sed_pkg::S_DATA_W-1:0]   s_axis_tdata,
	// line_start
	input  wire logic [0:0]                     s_axis_tuser,
	// result stream
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// edgel_pixel, edgel_line, edgel_strength, zero pad
	output logic [sed_pkg::M_DATA_W-1:0]        m_axis_tdata,
	// edgel_found
	output logic [0:0]                          m_axis_tuser
);

	logic                   push_valid;
	logic                   push_ready;
	sed_pkg::entry_t        push_data;
	logic                   pop_valid;
	logic                   pop_ready;
	sed_pkg::entry_t        pop_data;
	sed_pkg::result_t       res;

	// Front: unpack the pixel transaction, update the window and classify
	// the window centre against the threshold.
	sed_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.pix         (s_axis_tdata[sed_pkg::PIX_W-1:0]),
		.line_start  (s_axis_tuser[0]),
		.pixel_index (s_axis_tdata[sed_pkg::PIX_W +: sed_pkg::IDX_W]),
		.line_number (s_axis_tdata[sed_pkg::PIX_W + sed_pkg::IDX_W +: sed_pkg::IDX_W]),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	// Queue: absorb output stalls without blocking the pixel stream at once.
	sed_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// Back: local-maximum test on the response history, then register the result.
	sed_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (res)
	);

	// Pack the result: pixel lowest, then line, then strength; zero pad on top.
	assign m_axis_tdata = sed_pkg::M_DATA_W'({res.strength, res.line, res.pixel});
	assign m_axis_tuser = res.found;

endmodule

`default_nettype wire

// ===== rtl/sed_checker.sv =====
`default_nettype none

`include "scanline_edgel_detector_macros.svh"

module sed_checker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	input  wire logic [sed_pkg::M_DATA_W-1:0] m_axis_tdata,
	input  wire logic [0:0]                   m_axis_tuser
);

	logic last_found_q;
	logic out_xfer;

	assign out_xfer = m_axis_tvalid && m_axis_tready;

	// remember whether the last result transaction reported an edgel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_found_q <= 1'b0;
		end else if (out_xfer) begin
			last_found_q <= m_axis_tuser[0];
		end
	end

	`SED_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
	`SED_ASSERT_IMP(a_no_edgel_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0, "result without edgel carries data")
	`SED_ASSERT_IMP(a_edgel_strength, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[2*sed_pkg::IDX_W +: sed_pkg::RESP_W] != '0, "edgel with zero strength")
	`SED_ASSERT_IMP(a_no_adjacent, clk, arst_n, out_xfer && last_found_q, !m_axis_tuser[0], "edgels on adjacent pixels")

endmodule

bind scanline_edgel_detector sed_checker u_sed_checker (.*);

`default_nettype wire

// ===== test/scanline_edgel_detector_tb.sv =====
`default_nettype none

module scanline_edgel_detector_tb;

	// One pixel transaction as the sender sees it.
	typedef struct packed {
		logic                      line_start;
		logic [sed_pkg::IDX_W-1:0]  line_number;
		logic [sed_pkg::IDX_W-1:0]  pixel_index;
		logic [sed_pkg::CHAN_W-1:0] blue;
		logic [sed_pkg::CHAN_W-1:0] green;
		logic [sed_pkg::CHAN_W-1:0] red;
	} pixel_item_t;

	// Edgel predictor: mirrors the window, the response history and the
	// threshold, and keeps the results still due from the block in order.
	class edgel_scoreboard;
		logic [sed_pkg::PIX_W-1:0]  window [sed_pkg::WIN_DEPTH];
		logic [sed_pkg::FILL_W-1:0] fill;
		logic [sed_pkg::RESP_W-1:0] resp_prev1;
		logic [sed_pkg::RESP_W-1:0] resp_prev2;
		logic [sed_pkg::RESP_W-1:0] threshold;
		sed_pkg::result_t           edgels_due [$];
		int                         mismatches;

		function new();
			clear_line();
			threshold  = sed_pkg::THRESH_RESET;
			mismatches = 0;
		endfunction

		function void clear_line();
			foreach (window[i])
				window[i] = '0;
			fill       = '0;
			resp_prev1 = '0;
			resp_prev2 = '0;
		endfunction

		function int pending();
			return edgels_due.size();
		endfunction

		// |-3a - 5b + 5d + 3e|, at most 2040 for 8-bit samples
		function logic [sed_pkg::RESP_W-1:0] kernel_mag(int a, int b, int d, int e);
			int v;
			v = -3 * a - 5 * b + 5 * d + 3 * e;
			if (v < 0)
				v = -v;
			return sed_pkg::RESP_W'(v);
		endfunction

		function void take_pixel(pixel_item_t px);
			logic [sed_pkg::PIX_W-1:0]  pix;
			logic [sed_pkg::RESP_W-1:0] mag;
			logic [sed_pkg::RESP_W-1:0] red_mag;
			logic [sed_pkg::RESP_W-1:0] current;
			bit                         all_above;
			sed_pkg::result_t           due;
			pix = {px.blue, px.green, px.red};
			if (px.line_start)
				clear_line();
			current = '0;
			red_mag = '0;
			// the centre pixel (window[2]) has a zero tap
			if (fill >= sed_pkg::WIN_DEPTH) begin
				all_above = 1'b1;
				for (int c = 0; c < sed_pkg::NUM_CHAN; c++) begin
					mag = kernel_mag(int'(window[0][sed_pkg::CHAN_W*c +: sed_pkg::CHAN_W]),
						int'(window[1][sed_pkg::CHAN_W*c +: sed_pkg::CHAN_W]),
						int'(window[3][sed_pkg::CHAN_W*c +: sed_pkg::CHAN_W]),
						int'(pix[sed_pkg::CHAN_W*c +: sed_pkg::CHAN_W]));
					if (c == 0)
						red_mag = mag;
					if (!(mag > threshold))
						all_above = 1'b0;
				end
				if (all_above)
					current = red_mag;
			end
			due = '0;
			if (resp_prev1 != 0 && resp_prev1 > resp_prev2 && resp_prev1 > current) begin
				due.found    = 1'b1;
				due.pixel    = px.pixel_index - sed_pkg::IDX_W'(sed_pkg::EDGEL_LAG);
				due.line     = px.line_number;
				due.strength = resp_prev1;
			end
			edgels_due = {edgels_due, due};
			resp_prev2 = resp_prev1;
			resp_prev1 = current;
			for (int i = 0; i < sed_pkg::WIN_DEPTH - 1; i++)
				window[i] = window[i + 1];
			window[sed_pkg::WIN_DEPTH - 1] = pix;
			if (fill < sed_pkg::WIN_DEPTH)
				fill++;
		endfunction

		function void flag(string what, logic [31:0] want, logic [31:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("edgel mismatch: %s expected %0h actual %0h", what, want, got);
		endfunction

		function void check_edgel(sed_pkg::result_t got);
			sed_pkg::result_t want;
			if (edgels_due.size() == 0) begin
				flag("result with none due, found", 32'(0), 32'(got.found));
				return;
			end
			want = edgels_due.pop_front();
			if (got.found !== want.found)
				flag("edgel_found", 32'(want.found), 32'(got.found));
			if (got.pixel !== want.pixel)
				flag("edgel_pixel", 32'(want.pixel), 32'(got.pixel));
			if (got.line !== want.line)
				flag("edgel_line", 32'(want.line), 32'(got.line));
			if (got.strength !== want.strength)
				flag("edgel_strength", 32'(want.strength), 32'(got.strength));
		endfunction
	endclass

	logic                         clk           = 1'b0;
	logic                         arst_n        = 1'b0;
	logic                         cfg_we        = 1'b0;
	logic [sed_pkg::RESP_W-1:0]   cfg_wdata     = '0;
	logic                         s_axis_tvalid = 1'b0;
	logic                         s_axis_tready;
	// red, green, blue, pixel_index, line_number
	logic [sed_pkg::S_DATA_W-1:0] s_axis_tdata  = '0;
	// line_start
	logic [0:0]                   s_axis_tuser  = '0;
	logic                         m_axis_tvalid;
	logic                         m_axis_tready = 1'b0;
	// edgel_pixel, edgel_line, edgel_strength, zero pad
	logic [sed_pkg::M_DATA_W-1:0] m_axis_tdata;
	// edgel_found
	logic [0:0]                   m_axis_tuser;

	edgel_scoreboard  sb;
	sed_pkg::result_t seen_edgel;
	int               pixels_sent = 0;
	bit               steady      = 1'b0;  // both sides flow without gaps
	bit               long_hold   = 1'b0;  // ask the sink for one long hold-off

	scanline_edgel_detector i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offer one pixel and hold it until the block takes it. Entered and left at a
	// rising edge; tready is sampled at the falling edge, where it is settled, so
	// the transaction completes at the following rising edge.
	task automatic send_pixel(pixel_item_t px);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {px.line_number, px.pixel_index, px.blue, px.green, px.red};
		s_axis_tuser  <= px.line_start;
		do
			@(negedge clk);
		while (!s_axis_tready);
		@(posedge clk);
		sb.take_pixel(px);
		pixels_sent++;
	endtask

	task automatic send_rgb(int start, int idx, int line, int rgb);
		pixel_item_t px;
		px.line_start  = (start != 0);
		px.pixel_index = sed_pkg::IDX_W'(idx);
		px.line_number = sed_pkg::IDX_W'(line);
		{px.blue, px.green, px.red} = sed_pkg::PIX_W'(rgb);
		send_pixel(px);
	endtask

	// Drop valid and hold until every result due has been taken.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Write the threshold only while the block is empty.
	task automatic write_threshold(logic [sed_pkg::RESP_W-1:0] value);
		drain();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cfg_wdata <= sed_pkg::RESP_W'($urandom);
		sb.threshold = value;
	endtask

	function automatic logic [sed_pkg::PIX_W-1:0] pick_color();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return '1;
			default: return sed_pkg::PIX_W'($urandom);
		endcase
	endfunction

	// A scan line of flat runs with random colors, so that steps produce clear
	// peaks; sprinkle noisy pixels, stray line starts and index jumps into it.
	task automatic send_scan_line();
		pixel_item_t               px;
		logic [sed_pkg::PIX_W-1:0] color;
		int                        len;
		int                        run_left;
		bit                        with_start;
		len        = $urandom_range(5, 40);
		run_left   = 0;
		with_start = $urandom_range(0, 9) != 0;
		color      = '0;
		px.line_number = sed_pkg::IDX_W'($urandom);
		px.pixel_index = ($urandom_range(0, 9) == 0) ? sed_pkg::IDX_W'($urandom) : '0;
		for (int k = 0; k < len; k++) begin
			if (run_left == 0) begin
				color    = pick_color();
				run_left = $urandom_range(1, 6);
			end
			run_left--;
			if ($urandom_range(0, 4) == 0)
				{px.blue, px.green, px.red} = sed_pkg::PIX_W'($urandom);
			else
				{px.blue, px.green, px.red} = color;
			px.line_start = (k == 0) ? with_start : ($urandom_range(0, 99) == 0);
			if ($urandom_range(0, 49) == 0)
				px.pixel_index = sed_pkg::IDX_W'($urandom);
			send_pixel(px);
			px.pixel_index++;
		end
	endtask

	task automatic send_noise();
		pixel_item_t px;
		repeat ($urandom_range(1, 5)) begin
			px.red         = sed_pkg::CHAN_W'($urandom);
			px.green       = sed_pkg::CHAN_W'($urandom);
			px.blue        = sed_pkg::CHAN_W'($urandom);
			px.line_start  = ($urandom_range(0, 1) == 1);
			px.line_number = sed_pkg::IDX_W'($urandom);
			px.pixel_index = sed_pkg::IDX_W'($urandom);
			send_pixel(px);
		end
	endtask

	// Sink side: random stalls, plus one long hold-off on request.
	initial begin : result_sink
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				stall     = 90;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	// Check each result on the falling edge before the edge that takes it.
	always @(negedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_edgel.found    = m_axis_tuser[0];
			seen_edgel.pixel    = m_axis_tdata[sed_pkg::IDX_W-1:0];
			seen_edgel.line     = m_axis_tdata[2*sed_pkg::IDX_W-1:sed_pkg::IDX_W];
			seen_edgel.strength =
				m_axis_tdata[2*sed_pkg::IDX_W+sed_pkg::RESP_W-1:2*sed_pkg::IDX_W];
			sb.check_edgel(seen_edgel);
		end
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		logic [sed_pkg::RESP_W-1:0] thresholds [6];
		int                         phase_start;
		bit                         hold_done;
		bit                         pause_done;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset threshold. Soft step on the last line, starting near the
		// top of the index range so the edgel index wraps below zero.
		send_rgb(1, 4092, 4095, 24'h000000);
		send_rgb(0, 4093, 4095, 24'h000000);
		send_rgb(0, 4094, 4095, 24'h000000);
		send_rgb(0, 4095, 4095, 24'h808080);
		send_rgb(0, 0, 4095, 24'hFFFFFF);
		send_rgb(0, 1, 4095, 24'hFFFFFF);
		send_rgb(0, 2, 4095, 24'hFFFFFF);
		// continue the line without a line start
		send_rgb(0, 3, 4095, 24'h000000);
		send_rgb(0, 4, 4095, 24'h000000);
		// line cut short before the window fills
		send_rgb(1, 0, 0, 24'hFFFFFF);
		send_rgb(0, 1, 0, 24'h000000);
		send_rgb(0, 2, 0, 24'hFFFFFF);
		// step in red only: the other channels stay below threshold
		send_rgb(1, 4095, 12'h555, 24'h000000);
		send_rgb(0, 0, 12'h555, 24'h000000);
		send_rgb(0, 1, 12'h555, 24'h000000);
		send_rgb(0, 2, 12'h555, 24'h000080);
		send_rgb(0, 3, 12'h555, 24'h0000FF);
		send_rgb(0, 4, 12'h555, 24'h0000FF);

		thresholds[0] = '0;
		thresholds[1] = sed_pkg::RESP_W'($urandom_range(100, 400));
		thresholds[2] = '1;
		thresholds[3] = sed_pkg::RESP_W'(1);
		thresholds[4] = sed_pkg::RESP_W'($urandom_range(0, 2047));
		thresholds[5] = sed_pkg::RESP_W'($urandom_range(200, 900));
		hold_done  = 1'b0;
		pause_done = 1'b0;
		foreach (thresholds[p]) begin
			write_threshold(thresholds[p]);
			phase_start = pixels_sent;
			while (pixels_sent - phase_start < 315) begin
				steady = (pixels_sent - phase_start) < 40;
				// stall the sink for a long stretch while pixels keep coming
				if (p == 1 && !hold_done && pixels_sent - phase_start > 100) begin
					long_hold = 1'b1;
					hold_done = 1'b1;
				end
				// stop sending until every result has come back
				if (p == 3 && !pause_done && pixels_sent - phase_start > 150) begin
					drain();
					pause_done = 1'b1;
				end
				if ($urandom_range(0, 9) == 0)
					send_noise();
				else
					send_scan_line();
			end
		end
		steady = 1'b0;

		drain();
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
